// ----- design/sqmf_pkg.sv -----
package sqmf_pkg;

	localparam int PIX_W = 8;
	localparam int TAG_COORD_W = 10;
	localparam int HALF_DIVISOR = 2;

	// The queue between the front and back parts.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;
	localparam logic [QCNT_W:0] QUEUE_LIMIT = 4'd4;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW = 2'd2;

	localparam logic [10:0] RESET_WIDTH = 11'd1024;
	localparam logic [10:0] RESET_HEIGHT = 11'd1024;
	localparam logic [2:0] RESET_WINDOW = 3'd3;

	typedef struct packed {
		logic [TAG_COORD_W-1:0] col;
		logic [TAG_COORD_W-1:0] row;
		logic last;
	} tag_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic empty;
		logic full;
	} q_stat_t;

endpackage

// ----- design/sqmf_if.sv -----
interface sqmf_pix_if;
	logic valid;
	logic ready;
	logic [7:0] pixel;
	logic frame_start;

	modport source(output valid, output pixel, output frame_start, input ready);
	modport sink(input valid, input pixel, input frame_start, output ready);
endinterface

interface sqmf_med_if;
	logic valid;
	logic ready;
	logic [7:0] median_value;
	logic [9:0] out_col;
	logic [9:0] out_row;
	logic frame_last;

	modport source(output valid, output median_value, output out_col, output out_row,
		output frame_last, input ready);
	modport sink(input valid, input median_value, input out_col, input out_row,
		input frame_last, output ready);
endinterface

// ----- design/sqmf_ram.sv -----
module sqmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// A read of the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ----- design/sqmf_queue.sv -----
module sqmf_queue
	import sqmf_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] wdata,
	input logic pop,
	output logic [WIDTH-1:0] rdata,
	output q_stat_t stat
);
	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rptr_q];

	always_comb begin
		stat.count = cnt_q;
		stat.empty = (cnt_q == '0);
		stat.full = ({1'b0, cnt_q} == QUEUE_LIMIT);
	end
endmodule

// ----- design/sqmf_front.sv -----
module sqmf_front
	import sqmf_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 5,
	localparam int CW = $clog2(MAX_WIDTH + 1),
	localparam int RW = $clog2(MAX_HEIGHT + 1),
	localparam int KW = $clog2(MAX_WINDOW + 1),
	localparam int N = MAX_WINDOW * MAX_WINDOW,
	localparam int RKW = $clog2(N),
	localparam int QW = N * PIX_W + N + RKW + $bits(tag_t)
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [PIX_W-1:0] in_pixel,
	input logic in_frame_start,
	output logic in_ready,
	input logic [CW-1:0] w,
	input logic [RW-1:0] h,
	input logic [KW-1:0] k,
	input q_stat_t q_stat,
	output logic push,
	output logic [QW-1:0] push_data
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int COLW = MAX_WINDOW * PIX_W;
	localparam int LW = (MAX_WINDOW - 1) * PIX_W;

	logic acc;
	logic [CW-1:0] col_q, c0, col_n, left;
	logic [RW-1:0] row_q, r0, row_n, top;
	logic emit, last;

	logic s1_v;
	logic fwd_s1;
	logic emit_s1;
	logic [PIX_W-1:0] px_s1;
	logic [AW-1:0] col_s1;
	tag_t tag_s1;

	logic [LW-1:0] rdata, old, wvec, wvec_q;
	logic [COLW-1:0] colv;
	logic [N*PIX_W-1:0] win_q, win_n;
	logic [N-1:0] mask;
	logic [RKW-1:0] target;
	logic [QCNT_W:0] occ;

	assign occ = {1'b0, q_stat.count} + {{QCNT_W{1'b0}}, s1_v};
	assign in_ready = (occ < QUEUE_LIMIT);
	assign acc = in_valid && in_ready;

	// Position of the pixel being taken, wrapped at row and frame ends.
	always_comb begin
		c0 = in_frame_start ? '0 : col_q;
		r0 = in_frame_start ? '0 : row_q;
		if (c0 >= w) begin
			c0 = '0;
			r0 = r0 + 1'b1;
		end
		if (r0 >= h) begin
			r0 = '0;
		end
		emit = (CW'(k) <= w) && (RW'(k) <= h) && ((c0 + 1'b1) >= CW'(k))
			&& ((r0 + 1'b1) >= RW'(k));
		left = c0 + 1'b1 - CW'(k);
		top = r0 + 1'b1 - RW'(k);
		last = (c0 == w - 1'b1) && (r0 == h - 1'b1);
		if ((c0 + 1'b1) >= w) begin
			col_n = '0;
			row_n = ((r0 + 1'b1) >= h) ? '0 : r0 + 1'b1;
		end else begin
			col_n = c0 + 1'b1;
			row_n = r0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			s1_v <= 1'b0;
		end else begin
			s1_v <= acc;
			if (acc) begin
				col_q <= col_n;
				row_q <= row_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1 <= in_pixel;
			col_s1 <= c0[AW-1:0];
			emit_s1 <= emit;
			tag_s1.col <= TAG_COORD_W'(left);
			tag_s1.row <= TAG_COORD_W'(top);
			tag_s1.last <= last;
			// The column being written back this cycle is not yet in the RAM.
			fwd_s1 <= s1_v && (col_s1 == c0[AW-1:0]);
		end
		if (s1_v) begin
			wvec_q <= wvec;
			win_q <= win_n;
		end
	end

	// Each line store word holds the previous rows of one column, newest lowest.
	sqmf_ram #(
		.WIDTH(LW),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk(clk),
		.we(s1_v),
		.waddr(col_s1),
		.wdata(wvec),
		.re(acc),
		.raddr(c0[AW-1:0]),
		.rdata(rdata)
	);

	assign old = fwd_s1 ? wvec_q : rdata;
	assign colv = {old, px_s1};
	assign wvec = colv[LW-1:0];
	assign win_n = {win_q[(MAX_WINDOW-1)*COLW-1:0], colv};

	// Element j*MAX_WINDOW+e is column c-j, row r-e of the window.
	always_comb begin
		for (int j = 0; j < MAX_WINDOW; j++) begin
			for (int e = 0; e < MAX_WINDOW; e++) begin
				mask[j*MAX_WINDOW+e] = (j < int'(k)) && (e < int'(k));
			end
		end
		target = RKW'((int'(k) * int'(k)) / HALF_DIVISOR);
	end

	assign push = s1_v && emit_s1;
	assign push_data = {tag_s1, target, mask, win_n};
endmodule

// ----- design/sqmf_back.sv -----
module sqmf_back
	import sqmf_pkg::*;
#(
	parameter int MAX_WINDOW = 5,
	localparam int N = MAX_WINDOW * MAX_WINDOW,
	localparam int RKW = $clog2(N),
	localparam int QW = N * PIX_W + N + RKW + $bits(tag_t)
) (
	input logic clk,
	input logic arst_n,
	input q_stat_t q_stat,
	input logic [QW-1:0] q_data,
	output logic pop,
	output logic out_valid,
	input logic out_ready,
	output logic [PIX_W-1:0] out_median,
	output tag_t out_tag
);
	tag_t tag_in;
	logic [RKW-1:0] target_in;
	logic [N-1:0] mask_in;
	logic [N*PIX_W-1:0] win_in;
	logic [N-1:0] lt [N];
	logic en;

	logic b1_v_s1, b2_v_s2, out_v_q;
	logic [N*PIX_W-1:0] win_s1, win_s2;
	logic [N-1:0] mask_s1, mask_s2;
	logic [RKW-1:0] target_s1, target_s2;
	tag_t tag_s1, tag_s2;
	logic [N-1:0] lt_s1 [N];
	logic [RKW-1:0] rank_s2 [N];
	logic [PIX_W-1:0] sel;
	logic [PIX_W-1:0] med_q;
	tag_t tag_q;

	assign {tag_in, target_in, mask_in, win_in} = q_data;
	assign en = !out_v_q || out_ready;
	assign pop = en && !q_stat.empty;

	// Element i's rank is the count of window elements ordered before it;
	// ties are broken by position, so every rank occurs exactly once.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			for (int j = 0; j < N; j++) begin
				lt[i][j] = mask_in[j] && ((win_in[j*PIX_W +: PIX_W] < win_in[i*PIX_W +: PIX_W])
					|| ((win_in[j*PIX_W +: PIX_W] == win_in[i*PIX_W +: PIX_W]) && (j < i)));
			end
		end
	end

	always_comb begin
		sel = '0;
		for (int i = 0; i < N; i++) begin
			if (mask_s2[i] && (rank_s2[i] == target_s2)) begin
				sel = sel | win_s2[i*PIX_W +: PIX_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_s1 <= 1'b0;
			b2_v_s2 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			b1_v_s1 <= pop;
			b2_v_s2 <= b1_v_s1;
			out_v_q <= b2_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			win_s1 <= win_in;
			mask_s1 <= mask_in;
			target_s1 <= target_in;
			tag_s1 <= tag_in;
			lt_s1 <= lt;
			win_s2 <= win_s1;
			mask_s2 <= mask_s1;
			target_s2 <= target_s1;
			tag_s2 <= tag_s1;
			for (int i = 0; i < N; i++) begin
				rank_s2[i] <= RKW'($countones(lt_s1[i]));
			end
			med_q <= sel;
			tag_q <= tag_s2;
		end
	end

	assign out_valid = out_v_q;
	assign out_median = med_q;
	assign out_tag = tag_q;
endmodule

// ----- design/square_window_median_filter.sv -----
// Windows pass the front stage, the queue and the back s1, s2 and output registers.
// Throughput: one pixel per cycle while the queue has room; the line store RAM is read
// and written once per pixel. The back rank selection is fully pipelined: one window per
// cycle unless the output stalls. Reset (arst_n low) clears positions, queue and valid
// flags and sets width 1024, height 1024 and window 3; the line store needs no clearing.
module square_window_median_filter
	import sqmf_pkg::*;
#(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_WINDOW = 5
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	sqmf_pix_if.sink in_ch,
	sqmf_med_if.source out_ch
);
	localparam int CW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int KW = $clog2(MAX_WINDOW + 1);
	localparam int N = MAX_WINDOW * MAX_WINDOW;
	localparam int RKW = $clog2(N);
	localparam int QW = N * PIX_W + N + RKW + $bits(tag_t);

	logic [10:0] width_q, height_q;
	logic [2:0] window_q;
	logic [CW-1:0] w_cl;
	logic [RW-1:0] h_cl;
	logic [KW-1:0] k_cl;

	logic push, pop;
	logic [QW-1:0] push_data, q_data;
	q_stat_t q_stat;
	tag_t out_tag;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
			window_q <= RESET_WINDOW;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_WIDTH: width_q <= pwdata[10:0];
				REG_HEIGHT: height_q <= pwdata[10:0];
				REG_WINDOW: window_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_WIDTH: prdata = {21'd0, width_q};
			REG_HEIGHT: prdata = {21'd0, height_q};
			REG_WINDOW: prdata = {29'd0, window_q};
			default: prdata = '0;
		endcase
	end

	// A zero register acts as one, and values past the maxima saturate.
	always_comb begin
		if (width_q == '0) begin
			w_cl = CW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_cl = CW'(MAX_WIDTH);
		end else begin
			w_cl = CW'(width_q);
		end
		if (height_q == '0) begin
			h_cl = RW'(1);
		end else if (int'(height_q) > MAX_HEIGHT) begin
			h_cl = RW'(MAX_HEIGHT);
		end else begin
			h_cl = RW'(height_q);
		end
		if (window_q == '0) begin
			k_cl = KW'(1);
		end else if (int'(window_q) > MAX_WINDOW) begin
			k_cl = KW'(MAX_WINDOW);
		end else begin
			k_cl = KW'(window_q);
		end
	end

	sqmf_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.MAX_WINDOW(MAX_WINDOW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_pixel(in_ch.pixel),
		.in_frame_start(in_ch.frame_start),
		.in_ready(in_ch.ready),
		.w(w_cl),
		.h(h_cl),
		.k(k_cl),
		.q_stat(q_stat),
		.push(push),
		.push_data(push_data)
	);

	sqmf_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(push_data),
		.pop(pop),
		.rdata(q_data),
		.stat(q_stat)
	);

	sqmf_back #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_stat(q_stat),
		.q_data(q_data),
		.pop(pop),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_median(out_ch.median_value),
		.out_tag(out_tag)
	);

	assign out_ch.out_col = out_tag.col;
	assign out_ch.out_row = out_tag.row;
	assign out_ch.frame_last = out_tag.last;

	// The front admits a pixel only when the queue has room for its window.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_stat.full || pop))
		else $error("window pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("window popped from an empty queue");

	a_ready_room: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !q_stat.full)
		else $error("pixel taken while the queue is full");
endmodule

// ----- tb/sv/sqmf_tb_pkg.sv -----
`timescale 1ns / 1ps
package sqmf_tb_pkg;

	typedef struct packed {
		logic [7:0] median_value;
		logic [9:0] out_col;
		logic [9:0] out_row;
		logic frame_last;
	} median_t;

	class median_scoreboard;
		logic [7:0] lines [5][1024];
		int unsigned col_pos;
		int unsigned row_pos;
		int unsigned width_reg;
		int unsigned height_reg;
		int unsigned window_reg;
		median_t pending[$];
		int unsigned errors;
		int unsigned produced;

		function new();
			col_pos = 0;
			row_pos = 0;
			width_reg = 1024;
			height_reg = 1024;
			window_reg = 3;
			errors = 0;
			produced = 0;
		endfunction

		static function int unsigned clamp(int unsigned v, int unsigned top);
			if (v == 0)
				return 1;
			return (v > top) ? top : v;
		endfunction

		function void set_size(int unsigned w, int unsigned h, int unsigned k);
			width_reg = w;
			height_reg = h;
			window_reg = k;
		endfunction

		// Called once per pixel accepted by the block.
		function void note_pixel(logic [7:0] px, logic fs);
			int unsigned w, h, k, c, r, top, left, n, rank_idx;
			logic [7:0] vals[$];
			logic [7:0] t;
			median_t m;
			w = clamp(width_reg, 1024);
			h = clamp(height_reg, 1024);
			k = clamp(window_reg, 5);
			if (fs) begin
				col_pos = 0;
				row_pos = 0;
			end
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
			if (row_pos >= h)
				row_pos = 0;
			c = col_pos;
			r = row_pos;
			lines[r % 5][c] = px;
			if (k <= w && k <= h && c + 1 >= k && r + 1 >= k) begin
				top = r + 1 - k;
				left = c + 1 - k;
				for (int dr = 0; dr < k; dr++)
					for (int dc = 0; dc < k; dc++)
						vals.insert(vals.size(), lines[(top + dr) % 5][left + dc]);
				n = vals.size();
				for (int i = 1; i < n; i++)
					for (int j = i; j > 0 && vals[j-1] > vals[j]; j--) begin
						t = vals[j];
						vals[j] = vals[j-1];
						vals[j-1] = t;
					end
				rank_idx = (k * k) / 2;
				m.median_value = vals[rank_idx];
				m.out_col = left[9:0];
				m.out_row = top[9:0];
				m.frame_last = (c == w - 1 && r == h - 1);
				pending.insert(pending.size(), m);
			end
			col_pos = c + 1;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos = r + 1;
				if (row_pos >= h)
					row_pos = 0;
			end
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_median(median_t got);
			median_t exp_m;
			produced++;
			if (pending.size() == 0) begin
				report($sformatf("unexpected median %p", got));
				return;
			end
			exp_m = pending.pop_front();
			if (got.median_value !== exp_m.median_value)
				report($sformatf("median_value got %0d exp %0d at (%0d,%0d)",
					got.median_value, exp_m.median_value, exp_m.out_col, exp_m.out_row));
			if (got.out_col !== exp_m.out_col)
				report($sformatf("out_col got %0d exp %0d", got.out_col, exp_m.out_col));
			if (got.out_row !== exp_m.out_row)
				report($sformatf("out_row got %0d exp %0d", got.out_row, exp_m.out_row));
			if (got.frame_last !== exp_m.frame_last)
				report($sformatf("frame_last got %0b exp %0b at (%0d,%0d)",
					got.frame_last, exp_m.frame_last, exp_m.out_col, exp_m.out_row));
		endtask
	endclass

endpackage

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import sqmf_pkg::*;
	import sqmf_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sqmf_pix_if in_ch();
	sqmf_med_if out_ch();

	square_window_median_filter DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	median_scoreboard filter_sb = new();
	int unsigned pixels_sent = 0;
	int unsigned idle_cycles = 0;
	int unsigned frames_done = 0;
	bit stall_free = 1'b0;

	always #4 clk = ~clk;

	function automatic int unsigned gap_len();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Output side: random stalls, with no stalls at all in some phases.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				filter_sb.check_median({out_ch.median_value, out_ch.out_col,
					out_ch.out_row, out_ch.frame_last});
			if (stall_free)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(0, 99) < 70);
		end else begin
			out_ch.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic configure(logic [10:0] w, logic [10:0] h, logic [2:0] k);
		write_reg(REG_WIDTH, {21'd0, w});
		write_reg(REG_HEIGHT, {21'd0, h});
		write_reg(REG_WINDOW, {29'd0, k});
		filter_sb.set_size(w, h, k);
	endtask

	// Valid stays high after an accepted item so that the next one can follow at once;
	// it drops only for a gap or when the stream stops in drain.
	task automatic send_pixel(logic [7:0] px, logic fs, bit gaps);
		int unsigned g;
		g = gaps ? gap_len() : 0;
		if (g != 0) begin
			in_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel <= px;
		in_ch.frame_start <= fs;
		do @(posedge clk); while (!in_ch.ready);
		filter_sb.note_pixel(px, fs);
		pixels_sent++;
	endtask

	// Waits until every expected median has arrived, then lets the pipeline drain.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (filter_sb.pending.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// One frame of the configured size; style picks the pixel pattern.
	task automatic send_frame(int unsigned w, int unsigned h, int unsigned style, bit gaps);
		logic [7:0] px;
		for (int unsigned i = 0; i < w * h; i++) begin
			case (style)
				0: px = 8'h00;
				1: px = 8'hFF;
				2: px = (i % 2) ? 8'hFF : 8'h00;
				3: px = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'hFF;
				default: px = 8'($urandom_range(0, 255));
			endcase
			send_pixel(px, i == 0, gaps);
		end
		frames_done++;
	endtask

	initial begin
		int unsigned w, h, k, cnt;
		in_ch.valid = 1'b0;
		in_ch.pixel = '0;
		in_ch.frame_start = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: smallest sizes, extremes of pixel values and window shapes.
		configure(11'd4, 11'd3, 3'd3);
		send_frame(4, 3, 0, 0);
		send_frame(4, 3, 1, 0);
		drain();
		configure(11'd3, 11'd3, 3'd2);
		send_frame(3, 3, 2, 1);
		drain();
		// Window larger than frame gives no results; zero width acts as one.
		configure(11'd0, 11'd2, 3'd5);
		send_frame(1, 2, 4, 0);
		drain();
		// Oversized registers saturate; only a few pixels of a wide row go in.
		configure(11'h7FF, 11'd1024, 3'd7);
		for (int i = 0; i < 6; i++)
			send_pixel(8'($urandom_range(0, 255)), i == 0, 1);
		drain();
		configure(11'd5, 11'd5, 3'd0);
		send_frame(5, 5, 4, 1);
		drain();

		// Random frames; frames after the first run on, seldom with frame_start.
		while (pixels_sent < 1950) begin
			k = $urandom_range(1, 5);
			w = $urandom_range(k, 12);
			h = $urandom_range(k, 8);
			if ($urandom_range(0, 15) == 0)
				w = $urandom_range(1, 4);
			if ($urandom_range(0, 19) == 0) begin
				w = $urandom_range(32, 64);
				h = k;
			end
			stall_free = ($urandom_range(0, 3) == 0);
			configure(w[10:0], h[10:0], k[2:0]);
			cnt = $urandom_range(1, 3);
			send_frame(w, h, $urandom_range(3, 6), !stall_free);
			for (int unsigned f = 1; f < cnt; f++)
				for (int unsigned i = 0; i < w * h; i++)
					send_pixel(8'($urandom_range(0, 255)),
						$urandom_range(0, 30) == 0 && i == 0, !stall_free);
			drain();
		end

		$display("sent %0d pixels in %0d directed/random frame phases, checked %0d medians",
			pixels_sent, frames_done, filter_sb.produced);
		if (filter_sb.errors == 0 && filter_sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
design/sqmf_pkg.sv
design/sqmf_if.sv
design/sqmf_ram.sv
design/sqmf_queue.sv
design/sqmf_front.sv
design/sqmf_back.sv
design/square_window_median_filter.sv
tb/sv/sqmf_tb_pkg.sv
tb/sv/testbench.sv
